// ===== src/tkd_pkg.sv =====
package tkd_pkg;

	localparam int KIND_W      = 4;
	localparam int CODE_W      = 16;
	localparam int TIMER_W     = 16;
	localparam int SEQ_W       = 5;
	localparam int UVAL_W      = 21;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int RES_SLOTS   = 3;

	localparam logic [TIMER_W-1:0] TIMEOUT_RESET   = 16'd50;
	localparam logic [SEQ_W-1:0]   SEQ_LIMIT_RESET = 5'd16;

	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_TIMEOUT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEQUENCE_LIMIT = 2'd1;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [7:0] CH_ETX       = 8'h03;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_ESC       = 8'h1b;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_LBRACKET  = 8'h5b;
	localparam logic [7:0] CH_DEL       = 8'h7f;
	localparam logic [7:0] CH_UP        = 8'h41;
	localparam logic [7:0] CH_DOWN      = 8'h42;
	localparam logic [7:0] CH_RIGHT     = 8'h43;
	localparam logic [7:0] CH_LEFT      = 8'h44;
	localparam logic [7:0] CSI_FINAL_LO = 8'h40;
	localparam logic [7:0] CSI_FINAL_HI = 8'h7e;

	localparam logic [CODE_W-1:0] CODE_REPLACEMENT = 16'hfffd;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} tkd_in_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [CODE_W-1:0] code_unit;
		logic              last_of_run;
	} tkd_out_t;

	typedef enum logic [KIND_W-1:0] {
		EV_UP        = 4'd0,
		EV_DOWN      = 4'd1,
		EV_ENTER     = 4'd2,
		EV_BACK      = 4'd3,
		EV_BACKSPACE = 4'd4,
		EV_CHAR      = 4'd5,
		EV_DETACH    = 4'd6,
		EV_LINES     = 4'd7,
		EV_LINEBYTE  = 4'd8
	} tkd_event_t;

	typedef enum logic [1:0] {
		MODE_UNDECIDED = 2'd0,
		MODE_KEYS      = 2'd1,
		MODE_LINES     = 2'd2,
		MODE_CLOSED    = 2'd3
	} tkd_mode_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2
	} tkd_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_ENTRY  = 3'd1,
		ST_DRAIN  = 3'd2,
		ST_KEY    = 3'd3,
		ST_FINISH = 3'd4
	} tkd_state_t;

	typedef struct packed {
		logic load;
		logic entry;
		logic key_step;
		logic drain;
		logic finish;
	} tkd_cmd_t;

	typedef struct packed {
		logic buf_empty;
		logic key_active;
		logic hold_valid;
		logic out_free;
	} tkd_status_t;

	// Characters of the announcement "lines\r\n".
	function automatic logic [7:0] announce_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h6c;
			3'd1:    c = 8'h69;
			3'd2:    c = 8'h6e;
			3'd3:    c = 8'h65;
			3'd4:    c = 8'h73;
			3'd5:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

endpackage

// ===== src/tkd_ctrl.sv =====
module tkd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  tkd_pkg::tkd_status_t status,
	output tkd_pkg::tkd_cmd_t    cmd
);
	import tkd_pkg::*;

	tkd_state_t state_q;
	tkd_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (byte_valid) state_next = ST_ENTRY;
			end
			ST_ENTRY: begin
				state_next = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.buf_empty) state_next = status.key_active ? ST_KEY : ST_FINISH;
			end
			ST_KEY: begin
				state_next = ST_DRAIN;
			end
			ST_FINISH: begin
				if (!status.hold_valid || status.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		byte_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				byte_ready = 1'b1;
				cmd.load   = byte_valid;
			end
			ST_ENTRY:  cmd.entry    = 1'b1;
			ST_DRAIN:  cmd.drain    = 1'b1;
			ST_KEY:    cmd.key_step = 1'b1;
			ST_FINISH: cmd.finish   = 1'b1;
			default:   cmd          = '0;
		endcase
	end

endmodule

// ===== src/tkd_datapath.sv =====
module tkd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tkd_pkg::tkd_cmd_t                     cmd,
	output tkd_pkg::tkd_status_t                  status,
	input  tkd_pkg::tkd_in_t                      byte_item,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tkd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tkd_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  event_valid,
	input  logic                                  event_ready,
	output tkd_pkg::tkd_out_t                     event_item
);
	import tkd_pkg::*;

	// Configuration registers.
	logic [TIMER_W-1:0] timeout_q;
	logic [SEQ_W-1:0]   limit_q;

	// Captured input item.
	logic       op_q;
	logic [7:0] byte_q;

	// Decoder state.
	tkd_mode_t          mode_q, n_mode;
	logic [2:0]         matched_q, n_matched;
	tkd_phase_t         phase_q, n_phase;
	logic [SEQ_W-1:0]   seq_q, n_seq;
	logic               skip_q, n_skip;
	logic [UVAL_W-1:0]  uval_q, n_uval;
	logic [1:0]         urem_q, n_urem;
	logic [TIMER_W-1:0] timer_q, n_timer;
	logic               run_q, n_run;

	// Replay sequencing: k_q held bytes, then the captured byte.
	logic [2:0] k_q, n_k;
	logic [2:0] idx_q, n_idx;
	logic       kact_q, n_kact;

	// Results of one decode step.
	logic [KIND_W-1:0] res_kind [RES_SLOTS];
	logic [CODE_W-1:0] res_code [RES_SLOTS];
	logic [1:0]        res_n;

	logic [KIND_W-1:0] buf_kind_q [RES_SLOTS];
	logic [CODE_W-1:0] buf_code_q [RES_SLOTS];
	logic [1:0]        buf_cnt_q;
	logic [1:0]        buf_rd_q;

	logic              hold_v_q;
	logic [KIND_W-1:0] hold_kind_q;
	logic [CODE_W-1:0] hold_code_q;

	logic     out_v_q;
	tkd_out_t out_q;

	// Combinational temporaries.
	logic [7:0]         kb;
	logic [TIMER_W-1:0] timer_inc;
	logic [SEQ_W:0]     seq_next;
	logic               general;
	logic               lead_ok;
	logic [7:0]         lo, hi;
	logic [UVAL_W-1:0]  cp, cpv;

	logic buf_has, out_free, move, push;

	always_comb begin
		n_mode    = mode_q;
		n_matched = matched_q;
		n_phase   = phase_q;
		n_seq     = seq_q;
		n_skip    = skip_q;
		n_uval    = uval_q;
		n_urem    = urem_q;
		n_timer   = timer_q;
		n_run     = run_q;
		n_k       = k_q;
		n_idx     = idx_q;
		n_kact    = kact_q;
		res_n     = 2'd0;
		for (int i = 0; i < RES_SLOTS; i++) begin
			res_kind[i] = EV_UP;
			res_code[i] = '0;
		end
		kb        = (idx_q != k_q) ? announce_char(idx_q) : byte_q;
		timer_inc = timer_q;
		seq_next  = {1'b0, seq_q} + 6'd1;
		general   = 1'b0;
		lead_ok   = 1'b1;
		lo        = 8'h80;
		hi        = 8'hbf;
		cp        = {uval_q[UVAL_W-7:0], kb[5:0]};
		cpv       = cp - 21'h10000;

		if (cmd.entry) begin
			if (op_q == OP_TICK) begin
				if (mode_q == MODE_KEYS && run_q) begin
					timer_inc = (timer_q != '1) ? timer_q + 16'd1 : timer_q;
					if (timer_inc >= timeout_q) begin
						n_run   = 1'b0;
						n_timer = '0;
						if (phase_q == PH_ESC) begin
							n_phase         = PH_IDLE;
							n_seq           = '0;
							res_kind[res_n] = EV_BACK;
							res_n           = res_n + 2'd1;
						end
					end else begin
						n_timer = timer_inc;
					end
				end
			end else begin
				case (mode_q)
					MODE_UNDECIDED: begin
						if (byte_q == CH_LF && (matched_q == 3'd5 || matched_q == 3'd6)) begin
							n_mode          = MODE_LINES;
							n_matched       = '0;
							res_kind[res_n] = EV_LINES;
							res_n           = res_n + 2'd1;
						end else if (matched_q < 3'd6 && byte_q == announce_char(matched_q)) begin
							n_matched = matched_q + 3'd1;
						end else begin
							n_mode    = MODE_KEYS;
							n_matched = '0;
							n_k       = matched_q;
							n_idx     = '0;
							n_kact    = 1'b1;
						end
					end
					MODE_KEYS: begin
						n_k    = '0;
						n_idx  = '0;
						n_kact = 1'b1;
					end
					MODE_LINES: begin
						res_kind[res_n] = EV_LINEBYTE;
						res_code[res_n] = {8'd0, byte_q};
						res_n           = res_n + 2'd1;
					end
					default: begin
					end
				endcase
			end
		end else if (cmd.key_step) begin
			if (idx_q == k_q) n_kact = 1'b0;
			else n_idx = idx_q + 3'd1;

			if (mode_q == MODE_KEYS) begin
				if (phase_q == PH_CSI) begin
					if (kb >= CSI_FINAL_LO && kb <= CSI_FINAL_HI) begin
						n_phase = PH_IDLE;
						n_seq   = '0;
						case (kb)
							CH_UP: begin
								res_kind[res_n] = EV_UP;
								res_n           = res_n + 2'd1;
							end
							CH_DOWN: begin
								res_kind[res_n] = EV_DOWN;
								res_n           = res_n + 2'd1;
							end
							CH_RIGHT: begin
								res_kind[res_n] = EV_ENTER;
								res_n           = res_n + 2'd1;
							end
							CH_LEFT: begin
								res_kind[res_n] = EV_BACK;
								res_n           = res_n + 2'd1;
							end
							default: begin
							end
						endcase
					end else if (seq_next > {1'b0, limit_q}) begin
						n_phase = PH_IDLE;
						n_seq   = '0;
					end else begin
						n_seq = seq_next[SEQ_W-1:0];
					end
				end else begin
					general = 1'b1;
					if (phase_q == PH_ESC) begin
						n_run   = 1'b0;
						n_timer = '0;
						if (kb == CH_LBRACKET) begin
							general = 1'b0;
							if (limit_q < 5'd2) begin
								n_phase = PH_IDLE;
								n_seq   = '0;
							end else begin
								n_phase = PH_CSI;
								n_seq   = 5'd2;
							end
						end else begin
							n_phase         = PH_IDLE;
							n_seq           = '0;
							res_kind[res_n] = EV_BACK;
							res_n           = res_n + 2'd1;
						end
					end
				end

				if (general) begin
					if (kb != CH_LF) n_skip = 1'b0;
					if (kb == CH_ESC) begin
						n_phase = PH_ESC;
						n_seq   = 5'd1;
						n_timer = '0;
						n_run   = 1'b1;
					end else if (kb == CH_CR) begin
						n_skip          = 1'b1;
						res_kind[res_n] = EV_ENTER;
						res_n           = res_n + 2'd1;
					end else if (kb == CH_LF) begin
						if (!skip_q) begin
							res_kind[res_n] = EV_ENTER;
							res_n           = res_n + 2'd1;
						end
						n_skip = 1'b0;
					end else if (kb == CH_DEL || kb == CH_BS) begin
						res_kind[res_n] = EV_BACKSPACE;
						res_n           = res_n + 2'd1;
					end else if (kb == CH_ETX) begin
						res_kind[res_n] = EV_DETACH;
						res_n           = res_n + 2'd1;
						n_mode          = MODE_CLOSED;
						n_phase         = PH_IDLE;
						n_seq           = '0;
						n_timer         = '0;
						n_run           = 1'b0;
					end else if (kb >= CH_SPACE) begin
						if (urem_q != 2'd0) begin
							if (urem_q == 2'd2 && uval_q < 21'h10) begin
								if (uval_q == 21'h0) lo = 8'ha0;
								if (uval_q == 21'hd) hi = 8'h9f;
							end else if (urem_q == 2'd3) begin
								if (uval_q == 21'h0) lo = 8'h90;
								if (uval_q == 21'h4) hi = 8'h8f;
							end
							if (kb >= lo && kb <= hi) begin
								lead_ok = 1'b0;
								n_urem  = urem_q - 2'd1;
								if (urem_q == 2'd1) begin
									n_uval = '0;
									if (cp[UVAL_W-1:16] != '0) begin
										res_kind[res_n] = EV_CHAR;
										res_code[res_n] = 16'hd800 | {6'd0, cpv[19:10]};
										res_n           = res_n + 2'd1;
										res_kind[res_n] = EV_CHAR;
										res_code[res_n] = 16'hdc00 | {6'd0, cpv[9:0]};
										res_n           = res_n + 2'd1;
									end else begin
										res_kind[res_n] = EV_CHAR;
										res_code[res_n] = cp[15:0];
										res_n           = res_n + 2'd1;
									end
								end else begin
									n_uval = cp;
								end
							end else begin
								res_kind[res_n] = EV_CHAR;
								res_code[res_n] = CODE_REPLACEMENT;
								res_n           = res_n + 2'd1;
								n_urem          = '0;
								n_uval          = '0;
							end
						end
						if (lead_ok) begin
							if (kb < 8'h80) begin
								res_kind[res_n] = EV_CHAR;
								res_code[res_n] = {8'd0, kb};
								res_n           = res_n + 2'd1;
							end else if (kb >= 8'hc2 && kb <= 8'hdf) begin
								n_uval = {16'd0, kb[4:0]};
								n_urem = 2'd1;
							end else if (kb >= 8'he0 && kb <= 8'hef) begin
								n_uval = {17'd0, kb[3:0]};
								n_urem = 2'd2;
							end else if (kb >= 8'hf0 && kb <= 8'hf4) begin
								n_uval = {18'd0, kb[2:0]};
								n_urem = 2'd3;
							end else begin
								res_kind[res_n] = EV_CHAR;
								res_code[res_n] = CODE_REPLACEMENT;
								res_n           = res_n + 2'd1;
							end
						end
					end
				end
			end
		end
	end

	assign buf_has  = buf_rd_q != buf_cnt_q;
	assign out_free = !out_v_q || event_ready;
	assign move     = cmd.drain && buf_has && (!hold_v_q || out_free);
	assign push     = hold_v_q && out_free && ((cmd.drain && buf_has) || cmd.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			limit_q   <= SEQ_LIMIT_RESET;
			mode_q    <= MODE_UNDECIDED;
			matched_q <= '0;
			phase_q   <= PH_IDLE;
			seq_q     <= '0;
			skip_q    <= 1'b0;
			uval_q    <= '0;
			urem_q    <= '0;
			timer_q   <= '0;
			run_q     <= 1'b0;
			k_q       <= '0;
			idx_q     <= '0;
			kact_q    <= 1'b0;
			buf_cnt_q <= '0;
			buf_rd_q  <= '0;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ESCAPE_TIMEOUT: timeout_q <= cfg_data[TIMER_W-1:0];
					CFG_SEQUENCE_LIMIT: limit_q   <= cfg_data[SEQ_W-1:0];
					default: begin
					end
				endcase
			end
			mode_q    <= n_mode;
			matched_q <= n_matched;
			phase_q   <= n_phase;
			seq_q     <= n_seq;
			skip_q    <= n_skip;
			uval_q    <= n_uval;
			urem_q    <= n_urem;
			timer_q   <= n_timer;
			run_q     <= n_run;
			k_q       <= n_k;
			idx_q     <= n_idx;
			kact_q    <= n_kact;
			if (cmd.entry || cmd.key_step) begin
				buf_cnt_q <= res_n;
				buf_rd_q  <= '0;
			end else if (move) begin
				buf_rd_q <= buf_rd_q + 2'd1;
			end
			if (move) hold_v_q <= 1'b1;
			else if (push) hold_v_q <= 1'b0;
			if (push) out_v_q <= 1'b1;
			else if (event_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= byte_item.opcode;
			byte_q <= byte_item.data_byte;
		end
		if (cmd.entry || cmd.key_step) begin
			buf_kind_q <= res_kind;
			buf_code_q <= res_code;
		end
		if (move) begin
			hold_kind_q <= buf_kind_q[buf_rd_q];
			hold_code_q <= buf_code_q[buf_rd_q];
		end
		if (push) begin
			out_q.event_kind  <= hold_kind_q;
			out_q.code_unit   <= hold_code_q;
			out_q.last_of_run <= cmd.finish;
		end
	end

	assign status.buf_empty  = !buf_has;
	assign status.key_active = kact_q;
	assign status.hold_valid = hold_v_q;
	assign status.out_free   = out_free;

	assign cfg_ready   = 1'b1;
	assign event_valid = out_v_q;
	assign event_item  = out_q;

endmodule

// ===== src/terminal_key_decoder_unit.sv =====
// Terminal key decoder: turns received terminal bytes and time ticks into menu events.
// Input requests arrive on byte_valid/byte_ready with byte_item (opcode 0 for a byte,
// 1 for a tick); events leave on event_valid/event_ready with event_item, and the
// last event caused by a request carries last_of_run. A request that causes no event
// produces nothing on the output channel.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 sets the escape timeout in ticks, index 1 the sequence limit.
// Each request passes through an entry step, a drain of its events and a final flush,
// plus a key step for every byte that goes through the key decoder; a failed announcement
// replays up to six held bytes before the current one. The controller visits each replayed
// byte in turn and drains its events one a cycle while the output stage can take them.
// Reset returns the session to the undecided mode and loads the register defaults
// (timeout 50 ticks, limit 16 bytes). When the receiver stalls, the last event sits
// in the output register and the next one in a hold register, and the controller
// waits; a new request is still accepted while the final event awaits collection.
module terminal_key_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_ready,
	input  tkd_pkg::tkd_in_t                byte_item,
	output logic                            event_valid,
	input  logic                            event_ready,
	output tkd_pkg::tkd_out_t               event_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tkd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tkd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tkd_pkg::*;

	tkd_cmd_t    cmd;
	tkd_status_t status;

	// The controller sequences each request: entry step, buffer drain, key decode steps
	// for each key-mode byte and replayed byte, and a final flush that marks the run end.
	tkd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// The datapath holds the session state, the decode logic and the output stage.
	tkd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.byte_item   (byte_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_item  (event_item)
	);

endmodule

// ===== bench/terminal_key_decoder_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the terminal key decoder.
//
// An initial block queues requests (terminal bytes and time ticks) phase by phase. A clocked
// driver offers them on the byte channel and, at every accepted request, runs the
// decoder model below, which appends the events that request should cause to a queue.
// A clocked monitor collects events and compares each one, field by field, with the oldest
// queued expectation.
//
// Configuration changes only happen once the block has gone quiet: the request queue is
// empty, every expected event has arrived, and the settling wait has passed,
// because a request that causes no event may still be working its way through.
//
// The session mode can only go one way after reset (undecided, then keys or lines, then
// closed after ctrl-C), and reset is applied once. Each seed therefore picks one route
// through the announcement: most runs fall into key mode, about one in four selects line
// mode. Ctrl-C is held back until the very end so that key mode stays open for the whole
// run. The last few requests then exercise the closed session.
module terminal_key_decoder_unit_test;
	import tkd_pkg::*;

	// Cycles to wait after the last expected event before touching the configuration. A
	// request that causes no event may still be inside the block, so this leaves a margin.
	localparam int SETTLE_CYCLES = 40;
	// Length of the one long stretch during which the receiver refuses every event.
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_EVENTS_PER_REQUEST = 7;
	// Beyond this many reports a broken build only floods the log.
	localparam int REPORT_LIMIT = 100;
	localparam logic [55:0] ANNOUNCE = {"lines", CH_CR, CH_LF};
	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	tkd_in_t byte_item = '0;
	logic event_valid;
	logic event_ready = 1'b0;
	tkd_out_t event_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	terminal_key_decoder_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_item (event_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Requests still to be offered, events still owed by the block, and the events of the
	// request currently being modelled.
	tkd_in_t pending_requests[$];
	tkd_out_t expected_events[$];
	tkd_out_t run_events[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// The sequencer bumps stall_orders to ask for one long receiver hold-off; the monitor
	// notices the change and counts the stretch out itself.
	int stall_orders = 0;
	int stall_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	tkd_out_t want;

	// Decoder model: configuration copies and state, at the widths of the block.
	logic [TIMER_W-1:0] lone_escape_ticks = TIMEOUT_RESET;
	logic [SEQ_W-1:0] csi_byte_limit = SEQ_LIMIT_RESET;
	tkd_mode_t cur_mode = MODE_UNDECIDED;
	logic [2:0] prefix_held = '0;
	tkd_phase_t esc_phase = PH_IDLE;
	logic [SEQ_W-1:0] csi_len = '0;
	logic swallow_lf = 1'b0;
	logic [UVAL_W-1:0] utf8_acc = '0;
	logic [1:0] utf8_left = '0;
	logic [TIMER_W-1:0] esc_ticks = '0;
	logic esc_armed = 1'b0;

	function automatic logic [7:0] announce_byte(input int k);
		return ANNOUNCE[55 - 8 * k -: 8];
	endfunction

	function automatic void emit(input tkd_event_t kind, input logic [CODE_W-1:0] code);
		tkd_out_t e;
		if (run_events.size() >= MAX_EVENTS_PER_REQUEST) return;
		e.event_kind = kind;
		e.code_unit = code;
		e.last_of_run = 1'b0;
		run_events.push_back(e);
	endfunction

	// Emits a code point as one UTF-16 unit, or as a surrogate pair above the basic plane.
	function automatic void emit_code_point(input logic [UVAL_W-1:0] cp);
		logic [UVAL_W-1:0] v;
		if (cp >= 21'h10000) begin
			v = cp - 21'h10000;
			emit(EV_CHAR, 16'hd800 | {6'd0, v[19:10]});
			emit(EV_CHAR, 16'hdc00 | {6'd0, v[9:0]});
		end else begin
			emit(EV_CHAR, cp[15:0]);
		end
	endfunction

	// Text bytes: UTF-8 assembly, with the replacement character for anything malformed. A
	// byte that breaks a pending sequence flushes it and is then taken as a fresh start.
	function automatic void decode_text_byte(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		if (utf8_left != 2'd0) begin
			lo = 8'h80;
			hi = 8'hbf;
			// Second byte limits rule out overlong forms, surrogates and values above U+10FFFF.
			if (utf8_left == 2'd2 && utf8_acc < 21'h10) begin
				if (utf8_acc == 21'h0) lo = 8'ha0;
				if (utf8_acc == 21'hd) hi = 8'h9f;
			end else if (utf8_left == 2'd3) begin
				if (utf8_acc == 21'h0) lo = 8'h90;
				if (utf8_acc == 21'h4) hi = 8'h8f;
			end
			if (b >= lo && b <= hi) begin
				utf8_acc = {utf8_acc[14:0], b[5:0]};
				utf8_left = utf8_left - 2'd1;
				if (utf8_left == 2'd0) begin
					emit_code_point(utf8_acc);
					utf8_acc = '0;
				end
				return;
			end
			emit(EV_CHAR, CODE_REPLACEMENT);
			utf8_left = '0;
			utf8_acc = '0;
		end
		if (b < 8'h80) begin
			emit(EV_CHAR, {8'h00, b});
		end else if (b >= 8'hc2 && b <= 8'hdf) begin
			utf8_acc = {16'd0, b[4:0]};
			utf8_left = 2'd1;
		end else if (b >= 8'he0 && b <= 8'hef) begin
			utf8_acc = {17'd0, b[3:0]};
			utf8_left = 2'd2;
		end else if (b >= 8'hf0 && b <= 8'hf4) begin
			utf8_acc = {18'd0, b[2:0]};
			utf8_left = 2'd3;
		end else begin
			emit(EV_CHAR, CODE_REPLACEMENT);
		end
	endfunction

	function automatic void decode_key_byte(input logic [7:0] b);
		int len;
		if (cur_mode != MODE_KEYS) return;
		if (esc_phase == PH_CSI) begin
			// Everything up to a final byte is held, control bytes included; the sequence is
			// dropped once it holds more bytes than the limit.
			len = int'(csi_len) + 1;
			if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) begin
				esc_phase = PH_IDLE;
				csi_len = '0;
				case (b)
					CH_UP:    emit(EV_UP, 16'h0);
					CH_DOWN:  emit(EV_DOWN, 16'h0);
					CH_RIGHT: emit(EV_ENTER, 16'h0);
					CH_LEFT:  emit(EV_BACK, 16'h0);
					default:  ;
				endcase
			end else if (len > int'(csi_byte_limit)) begin
				esc_phase = PH_IDLE;
				csi_len = '0;
			end else begin
				csi_len = SEQ_W'(len);
			end
			return;
		end
		if (esc_phase == PH_ESC) begin
			esc_armed = 1'b0;
			esc_ticks = '0;
			if (b == CH_LBRACKET) begin
				// The limit also applies to ESC and '[' themselves.
				if (csi_byte_limit < 5'd2) begin
					esc_phase = PH_IDLE;
					csi_len = '0;
				end else begin
					esc_phase = PH_CSI;
					csi_len = 5'd2;
				end
				return;
			end
			// A lone escape followed by anything else is back, then the byte as usual.
			esc_phase = PH_IDLE;
			csi_len = '0;
			emit(EV_BACK, 16'h0);
		end
		if (b != CH_LF) swallow_lf = 1'b0;
		if (b == CH_ESC) begin
			esc_phase = PH_ESC;
			csi_len = 5'd1;
			esc_ticks = '0;
			esc_armed = 1'b1;
		end else if (b == CH_CR) begin
			swallow_lf = 1'b1;
			emit(EV_ENTER, 16'h0);
		end else if (b == CH_LF) begin
			if (!swallow_lf) emit(EV_ENTER, 16'h0);
			swallow_lf = 1'b0;
		end else if (b == CH_DEL || b == CH_BS) begin
			emit(EV_BACKSPACE, 16'h0);
		end else if (b == CH_ETX) begin
			emit(EV_DETACH, 16'h0);
			cur_mode = MODE_CLOSED;
			esc_phase = PH_IDLE;
			csi_len = '0;
			esc_ticks = '0;
			esc_armed = 1'b0;
		end else if (b >= CH_SPACE) begin
			decode_text_byte(b);
		end
		// Remaining control bytes are ignored and leave the UTF-8 state alone.
	endfunction

	// Works out the events of one accepted request and queues them as owed.
	function automatic void decode_request(input tkd_in_t req);
		int k;
		int i;
		tkd_out_t e;
		run_events.delete();
		if (req.opcode == OP_TICK) begin
			// Ticks only matter in key mode while a lone escape waits.
			if (cur_mode == MODE_KEYS && esc_armed) begin
				if (esc_ticks != 16'hffff) esc_ticks = esc_ticks + 16'd1;
				if (esc_ticks >= lone_escape_ticks) begin
					esc_armed = 1'b0;
					esc_ticks = '0;
					if (esc_phase == PH_ESC) begin
						esc_phase = PH_IDLE;
						csi_len = '0;
						emit(EV_BACK, 16'h0);
					end
				end
			end
		end else if (cur_mode == MODE_UNDECIDED) begin
			k = (prefix_held < 3'd7) ? int'(prefix_held) : 6;
			if (req.data_byte == CH_LF && (k == 5 || k == 6)) begin
				cur_mode = MODE_LINES;
				prefix_held = '0;
				emit(EV_LINES, 16'h0);
			end else if (k < 6 && req.data_byte == announce_byte(k)) begin
				prefix_held = 3'(k + 1);
			end else begin
				// Not the announcement after all: replay what was held, then this byte.
				cur_mode = MODE_KEYS;
				prefix_held = '0;
				for (i = 0; i < k; i++) decode_key_byte(announce_byte(i));
				decode_key_byte(req.data_byte);
			end
		end else if (cur_mode == MODE_KEYS) begin
			decode_key_byte(req.data_byte);
		end else if (cur_mode == MODE_LINES) begin
			emit(EV_LINEBYTE, {8'h00, req.data_byte});
		end
		if (run_events.size() > 0) begin
			e = run_events.pop_back();
			e.last_of_run = 1'b1;
			run_events.push_back(e);
		end
		foreach (run_events[j]) expected_events.push_back(run_events[j]);
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		tkd_in_t r;
		r.opcode = OP_BYTE;
		r.data_byte = b;
		pending_requests.push_back(r);
	endfunction

	// The byte lane of a tick carries noise; the block must ignore it.
	function automatic void push_tick();
		tkd_in_t r;
		r.opcode = OP_TICK;
		r.data_byte = 8'($urandom);
		pending_requests.push_back(r);
	endfunction

	// A control byte that neither closes the session nor opens an escape.
	function automatic logic [7:0] pick_control();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 31)); while (b == CH_ETX || b == CH_ESC);
		return b;
	endfunction

	// Queues a mix of typing: mostly well-formed text, characters, escape sequences and
	// line ends, with a share of malformed UTF-8, overlong or unterminated sequences and
	// plain noise. Ctrl-C is never generated here.
	function automatic void queue_keyboard_traffic(input int fragments);
		int f;
		int pick;
		int n;
		int i;
		int cp;
		logic [7:0] b;
		for (f = 0; f < fragments; f++) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				n = $urandom_range(1, 4);
				repeat (n) push_byte(8'($urandom_range(32, 126)));
			end else if (pick < 33) begin
				// A valid character of two to four bytes, now and then with a control byte
				// in the middle, which must not disturb the pending character.
				n = $urandom_range(2, 4);
				case (n)
					2: begin
						cp = $urandom_range(32'h80, 32'h7ff);
						push_byte(8'(32'hc0 | (cp >> 6)));
					end
					3: begin
						cp = $urandom_range(32'h800, 32'hffff);
						if (cp >= 32'hd800 && cp <= 32'hdfff) cp = cp - 32'h800;
						push_byte(8'(32'he0 | (cp >> 12)));
					end
					default: begin
						cp = $urandom_range(32'h10000, 32'h10ffff);
						push_byte(8'(32'hf0 | (cp >> 18)));
					end
				endcase
				for (i = n - 2; i >= 0; i--) begin
					if ($urandom_range(0, 5) == 0) push_byte(pick_control());
					push_byte(8'(32'h80 | ((cp >> (6 * i)) & 32'h3f)));
				end
			end else if (pick < 43) begin
				// Malformed UTF-8: a lead byte with an arbitrary follower, or stray bytes.
				if ($urandom_range(0, 1) == 1) push_byte(8'($urandom_range(32'hc0, 32'hff)));
				n = $urandom_range(1, 2);
				repeat (n) push_byte(8'($urandom_range(32'h80, 32'hff)));
			end else if (pick < 63) begin
				// CSI sequence; the parameter count sometimes runs past the limit.
				push_byte(CH_ESC);
				push_byte(CH_LBRACKET);
				if ($urandom_range(0, 4) == 0) n = $urandom_range(0, int'(csi_byte_limit));
				else n = $urandom_range(0, 3);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) push_byte(pick_control());
					else push_byte(8'($urandom_range(32'h20, 32'h3f)));
				end
				if ($urandom_range(0, 9) < 7) push_byte(8'($urandom_range(CH_UP, CH_LEFT)));
				else push_byte(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
			end else if (pick < 75) begin
				// Lone escape, then ticks around the timeout, then maybe a letter.
				push_byte(CH_ESC);
				n = (lone_escape_ticks < 16'd8) ? int'(lone_escape_ticks) + 1 : 8;
				n = $urandom_range(0, n);
				repeat (n) push_tick();
				if ($urandom_range(0, 1) == 1) push_byte(8'($urandom_range(32'h61, 32'h7a)));
			end else if (pick < 85) begin
				case ($urandom_range(0, 4))
					0: push_byte(CH_CR);
					1: push_byte(CH_LF);
					2: begin
						push_byte(CH_CR);
						push_byte(CH_LF);
					end
					3: begin
						push_byte(CH_LF);
						push_byte(CH_LF);
					end
					default: begin
						push_byte(CH_CR);
						push_byte(CH_CR);
					end
				endcase
			end else if (pick < 90) begin
				push_byte(($urandom_range(0, 1) == 1) ? CH_DEL : CH_BS);
			end else if (pick < 95) begin
				n = $urandom_range(1, 3);
				repeat (n) push_tick();
			end else begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_ETX);
				push_byte(b);
			end
		end
	endfunction

	task automatic report_field(input string field, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
	endtask

	// Waits until every queued request has gone in and every owed event has come out,
	// then lets the block finish any request that produces nothing.
	task automatic settle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || byte_valid || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ESCAPE_TIMEOUT) lone_escape_ticks = data;
		else if (idx == CFG_SEQUENCE_LIMIT) csi_byte_limit = data[SEQ_W-1:0];
	endtask

	// Driver: models each request as it is accepted, then offers the next one unless it
	// decides to idle. A request on offer is held until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_item <= '0;
		end else begin
			if (byte_valid && byte_ready) decode_request(byte_item);
			if (!byte_valid || byte_ready) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					byte_valid <= 1'b1;
					byte_item <= pending_requests.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every collected event against the oldest one owed, and decides
	// from cycle to cycle whether to accept, including the one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_ready <= 1'b0;
		end else begin
			if (event_valid && event_ready) begin
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t ns: event with nothing expected, kind %h code %h last %h",
							$time, event_item.event_kind, event_item.code_unit,
							event_item.last_of_run);
				end else begin
					want = expected_events.pop_front();
					if (event_item.event_kind !== want.event_kind)
						report_field("event_kind", 16'(want.event_kind), 16'(event_item.event_kind));
					if (event_item.code_unit !== want.code_unit)
						report_field("code_unit", want.code_unit, event_item.code_unit);
					if (event_item.last_of_run !== want.last_of_run)
						report_field("last_of_run", 16'(want.last_of_run),
							16'(event_item.last_of_run));
				end
			end
			if (stall_served != stall_orders) begin
				stall_served = stall_orders;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				event_ready <= 1'b0;
			end else begin
				event_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin : sequencer
		int run_kind;
		int prefix;
		int i;
		logic [7:0] b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// First phases: a sluggish receiver behind a busy sender.
		send_idle_pct = 13;
		recv_idle_pct = 74;

		// Directed opening on the reset configuration. A tick before the mode is known is
		// ignored and must not disturb the announcement match.
		run_kind = $urandom_range(0, 3);
		push_tick();
		if (run_kind == 0) begin
			// Full announcement, with or without CR, then raw bytes in line mode.
			for (i = 0; i < 5; i++) push_byte(announce_byte(i));
			if ($urandom_range(0, 1) == 1) push_byte(CH_CR);
			push_byte(CH_LF);
			push_byte(8'h00);
			push_byte(8'hff);
			push_byte(CH_ETX);
			push_tick();
		end else begin
			if (run_kind == 1) begin
				// Short or empty prefix broken by a printable byte.
				prefix = $urandom_range(0, 5);
				for (i = 0; i < prefix; i++) push_byte(announce_byte(i));
				do b = 8'($urandom_range(32, 126)); while (b == announce_byte(prefix));
				push_byte(b);
			end else begin
				// "lines\r" broken by DEL: six replayed bytes plus a backspace, the most
				// events a single request can cause.
				for (i = 0; i < 6; i++) push_byte(announce_byte(i));
				push_byte(CH_DEL);
			end
			// CR LF is one enter.
			push_byte(CH_CR);
			push_byte(CH_LF);
			// Cursor up.
			push_byte(CH_ESC);
			push_byte(CH_LBRACKET);
			push_byte(CH_UP);
			// Lone escape followed by an ordinary letter: back, then the letter.
			push_byte(CH_ESC);
			push_byte(8'h78);
			// A control byte inside a two-byte character leaves it pending.
			push_byte(8'hc3);
			push_byte(8'h01);
			push_byte(8'ha9);
			// Four-byte character, giving a surrogate pair.
			push_byte(8'hf0);
			push_byte(8'h9f);
			push_byte(8'h98);
			push_byte(8'h80);
			// Encoded surrogate: broken at the second byte, which is then a bad lead.
			push_byte(8'hed);
			push_byte(8'ha0);
		end
		settle();

		// Zero timeout and a limit that drops a sequence at '['. While the queue is full the
		// receiver shuts off for a long stretch so that the block backs up into its input.
		write_register(CFG_ESCAPE_TIMEOUT, 16'd0);
		write_register(CFG_SEQUENCE_LIMIT, 16'd1);
		queue_keyboard_traffic(8);
		stall_orders++;
		settle();

		// Roles swapped: the sender now idles most of the time.
		send_idle_pct = 74;
		recv_idle_pct = 13;
		write_register(CFG_ESCAPE_TIMEOUT, 16'd1);
		write_register(CFG_SEQUENCE_LIMIT, 16'd3);
		queue_keyboard_traffic(8);
		settle();

		write_register(CFG_UNUSED, 16'($urandom));
		write_register(CFG_ESCAPE_TIMEOUT, 16'($urandom_range(1, 6)));
		write_register(CFG_SEQUENCE_LIMIT, {11'($urandom), 5'($urandom_range(3, 31))});
		queue_keyboard_traffic(8);
		settle();

		// No idling from here on. Largest settings, and in key mode one lone escape that a
		// few ticks cannot time out, so that only the following letter turns it into back.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(CFG_ESCAPE_TIMEOUT, 16'hffff);
		write_register(CFG_SEQUENCE_LIMIT, 16'd31);
		queue_keyboard_traffic(8);
		if (run_kind != 0) begin
			push_byte(8'h78);
			push_byte(CH_ESC);
			repeat (3) push_tick();
			push_byte(8'h79);
		end
		settle();

		write_register(CFG_ESCAPE_TIMEOUT, 16'($urandom_range(0, 4)));
		write_register(CFG_SEQUENCE_LIMIT, {11'($urandom), 5'($urandom_range(0, 31))});
		queue_keyboard_traffic(8);
		// The letter ends whatever escape may still be open, so that ctrl-C is seen as a
		// detach; after that the closed session must stay silent.
		push_byte(8'h78);
		push_byte(CH_ETX);
		push_byte(CH_ESC);
		push_byte(8'h61);
		push_tick();
		push_byte(CH_ETX);
		push_byte(8'hc3);
		push_tick();
		settle();

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Backstop for a block that stops answering. The slowest correct run stays well under
	// a tenth of this.
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
